// ===== hdl/imu_snp_packet_parser_defines.svh =====
// assertion macros for the snp packet parser
`ifndef IMU_SNP_PACKET_PARSER_DEFINES_SVH
`define IMU_SNP_PACKET_PARSER_DEFINES_SVH
// assert that a condition implies a consequence on the same edge
`define SNP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// assert that a condition implies a consequence on the next edge
`define SNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/snp_pkg.sv =====
// package of types and constants for the snp packet parser
`timescale 1ns / 1ps
`default_nettype none
package snp_pkg;
  localparam int unsigned BufferBytes   = 128;
  localparam int unsigned MaxBatchWords = 15;
  localparam logic [7:0] ChS = 8'h73;
  localparam logic [7:0] ChN = 8'h6e;
  localparam logic [7:0] ChP = 8'h70;
  localparam logic [7:0] TypeHasData = 8'h80;
  localparam logic [7:0] TypeBatch   = 8'h40;
  localparam logic [3:0] CountMask   = 4'hF;
  localparam int unsigned MaxResults = 64;
  // checksum seed: sum of the three header characters
  localparam logic [15:0] HdrSum = 16'(ChS) + 16'(ChN) + 16'(ChP);

  typedef enum logic [1:0] {
    EV_READY    = 2'd0,
    EV_GARBAGE  = 2'd1,
    EV_BAD_TYPE = 2'd2,
    EV_CSUM     = 2'd3
  } event_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TRIM_RD, ST_TRIM_CHK, ST_WRITE, ST_START,
    ST_SCAN_RD, ST_SCAN_CHK, ST_HDR_RD, ST_HDR_CHK, ST_SUM_RD, ST_SUM_ACC,
    ST_CK_RD, ST_CK_CMP, ST_WD_RD, ST_WD_ACC, ST_EMIT, ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  reg_address;
    logic [7:0]  type_byte;
    logic [5:0]  payload_bytes;
    logic [31:0] data_word;
    logic [3:0]  word_index;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

// ===== hdl/snp_if.sv =====
// valid/ready stream interface
`timescale 1ns / 1ps
`default_nettype none
interface snp_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/snp_ring.sv =====
// ring buffer memory holding received bytes with registered read
`timescale 1ns / 1ps
`default_nettype none
module snp_ring #(
  parameter int unsigned Depth = snp_pkg::BufferBytes,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);
  logic [7:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/imu_snp_packet_parser.sv =====
// top level of the snp packet parser: sequencer around a byte ring and one checksum adder
//
// snp packet parser. Each transfer on rx carries one byte; it is stored in a
// ring buffer of BUFFER_BYTES entries (a head index plus a fill count, so
// dropping bytes from the front only moves the head, and no clearing pass is
// needed after reset). rx is ready only while the sequencer is idle. A byte
// is accepted, written and then starts a parse run; a full buffer is first
// trimmed to a trailing "sn" or "s". Every parse run reads the ring through
// its single registered read port, a read state and a check state per byte:
// the header search examines positions from the front, then the type and
// address are read, the checksum pass sums the payload and compares the two
// checksum bytes, and a ready packet is read again to assemble its words.
// Each result passes through an emit state, a run restarts from the start
// state, and the step ends with a flush state that releases the final result
// with last set. A step may chain several runs (up to 64 results), and a
// stalled result side holds the step back, since one result is held back to
// learn whether it is the last and only one more fits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_snp_packet_parser_defines.svh"
module imu_snp_packet_parser #(
  parameter int unsigned BUFFER_BYTES    = snp_pkg::BufferBytes,
  parameter int unsigned MAX_BATCH_WORDS = snp_pkg::MaxBatchWords
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  snp_if.sink      rx,
  snp_if.source    res
);
  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [6:0] MaxDlen = 7'(4 * MAX_BATCH_WORDS);

  snp_pkg::state_e state_q, state_d;
  snp_pkg::state_e after_q, after_d;   // where to go once a result is parked
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] pos_q, pos_d;       // byte offset from the head
  logic [1:0]    sub_q, sub_d;       // byte within checksum / word
  logic [7:0]    b0_q, b0_d, b1_q, b1_d;
  logic [7:0]    typ_q, typ_d, addr_q, addr_d;
  logic [6:0]    dlen_q, dlen_d;
  logic [15:0]   sum_q, sum_d;
  logic [31:0]   word_q, word_d;
  logic [3:0]    widx_q, widx_d;
  logic [6:0]    nres_q, nres_d;     // results in this step
  logic [7:0]    rxb_q, rxb_d;
  snp_pkg::result_t out_q, out_d;
  logic          ovalid_q, ovalid_d;
  logic          pend_q, pend_d;     // a result held back for the last flag
  snp_pkg::result_t pres_q, pres_d;
  snp_pkg::result_t new_q, new_d;    // freshly produced result

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  snp_ring #(.Depth(BUFFER_BYTES)) u_ring (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {1'b0, CW'(h)} + {1'b0, off};
    if (s >= (CW+1)'(BUFFER_BYTES)) s = s - (CW+1)'(BUFFER_BYTES);
    return s[AW-1:0];
  endfunction

  // shared adder for the byte-sum checksum
  logic [15:0] add_y;
  assign add_y = sum_q + 16'(rdata);

  // decode of the type byte
  logic [3:0] cnt;
  logic [6:0] dlen_c;
  logic       bad_type;
  assign cnt      = typ_q[5:2] & snp_pkg::CountMask;
  assign dlen_c   = !typ_q[7] ? 7'd0 : (typ_q[6] ? {1'b0, cnt, 2'b00} : 7'd4);
  assign bad_type = (typ_q[7] && typ_q[6] && cnt == 4'd0) || (dlen_c > MaxDlen);

  // conditions shared by the sequencer and the datapath
  logic          trim_full, hdr_hit, scan_end, pkt_short, sum_ok, no_room;
  logic          sum_end, last_word, out_free;
  logic [CW-1:0] keep_c;
  logic [6:0]    words_need;
  assign trim_full = fill_q == CW'(BUFFER_BYTES);
  assign hdr_hit   = pos_q >= CW'(2) && b0_q == snp_pkg::ChS && b1_q == snp_pkg::ChN &&
                     rdata == snp_pkg::ChP;
  assign scan_end  = pos_q == fill_q - CW'(1);
  // trailing "sn" or "s" survives a trim
  assign keep_c    = (b1_q == snp_pkg::ChS && rdata == snp_pkg::ChN) ? CW'(2) :
                     (rdata == snp_pkg::ChS) ? CW'(1) : '0;
  assign pkt_short = fill_q < CW'(7) + CW'(dlen_c);
  assign sum_end   = pos_q == CW'(4) + CW'(dlen_q);
  assign sum_ok    = {b0_q, rdata} == sum_q;
  assign words_need = (dlen_q == '0) ? 7'd1 : {2'b00, dlen_q[6:2]};
  assign no_room   = nres_q + words_need > 7'(snp_pkg::MaxResults);
  assign last_word = widx_q == 4'(dlen_q[6:2] - 5'd1);
  assign out_free  = !ovalid_q || res.ready;

  // ring ports
  assign we    = state_q == snp_pkg::ST_WRITE;
  assign waddr = wrap(head_q, fill_q);
  assign wdata = rxb_q;
  assign raddr = wrap(head_q, pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= snp_pkg::ST_IDLE; after_q <= snp_pkg::ST_START;
      head_q <= '0; fill_q <= '0; ovalid_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      state_q <= state_d; after_q <= after_d;
      head_q <= head_d; fill_q <= fill_d; ovalid_q <= ovalid_d; pend_q <= pend_d;
    end
  end
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; sub_q <= sub_d; b0_q <= b0_d; b1_q <= b1_d;
    typ_q <= typ_d; addr_q <= addr_d; dlen_q <= dlen_d; sum_q <= sum_d;
    word_q <= word_d; widx_q <= widx_d; rxb_q <= rxb_d; out_q <= out_d;
    pres_q <= pres_d; new_q <= new_d; nres_q <= nres_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      snp_pkg::ST_IDLE: begin
        if (rx.valid) state_d = trim_full ? snp_pkg::ST_TRIM_RD : snp_pkg::ST_WRITE;
      end
      snp_pkg::ST_TRIM_RD: state_d = snp_pkg::ST_TRIM_CHK;
      snp_pkg::ST_TRIM_CHK: begin
        state_d = (sub_q == 2'd0) ? snp_pkg::ST_TRIM_RD : snp_pkg::ST_WRITE;
      end
      snp_pkg::ST_WRITE: state_d = snp_pkg::ST_START;
      snp_pkg::ST_START: begin
        if (fill_q < CW'(3) || nres_q >= 7'(snp_pkg::MaxResults)) state_d = snp_pkg::ST_FLUSH;
        else state_d = snp_pkg::ST_SCAN_RD;
      end
      snp_pkg::ST_SCAN_RD: state_d = snp_pkg::ST_SCAN_CHK;
      snp_pkg::ST_SCAN_CHK: begin
        if (hdr_hit) begin
          if (pos_q != CW'(2)) state_d = snp_pkg::ST_EMIT;
          else if (fill_q < CW'(7)) state_d = snp_pkg::ST_FLUSH;
          else state_d = snp_pkg::ST_HDR_RD;
        end else if (scan_end) state_d = snp_pkg::ST_EMIT;
        else state_d = snp_pkg::ST_SCAN_RD;
      end
      snp_pkg::ST_HDR_RD: state_d = snp_pkg::ST_HDR_CHK;
      snp_pkg::ST_HDR_CHK: begin
        if (pos_q == CW'(3)) state_d = snp_pkg::ST_HDR_RD;
        else if (bad_type) state_d = snp_pkg::ST_EMIT;
        else if (pkt_short) state_d = snp_pkg::ST_FLUSH;
        else if (dlen_c == '0) state_d = snp_pkg::ST_CK_RD;
        else state_d = snp_pkg::ST_SUM_RD;
      end
      snp_pkg::ST_SUM_RD: state_d = snp_pkg::ST_SUM_ACC;
      snp_pkg::ST_SUM_ACC: state_d = sum_end ? snp_pkg::ST_CK_RD : snp_pkg::ST_SUM_RD;
      snp_pkg::ST_CK_RD: state_d = snp_pkg::ST_CK_CMP;
      snp_pkg::ST_CK_CMP: begin
        if (sub_q == 2'd0) state_d = snp_pkg::ST_CK_RD;
        else if (!sum_ok) state_d = snp_pkg::ST_EMIT;
        else if (no_room) state_d = snp_pkg::ST_FLUSH;
        else if (dlen_q == '0) state_d = snp_pkg::ST_EMIT;
        else state_d = snp_pkg::ST_WD_RD;
      end
      snp_pkg::ST_WD_RD: state_d = snp_pkg::ST_WD_ACC;
      snp_pkg::ST_WD_ACC: state_d = (sub_q == 2'd3) ? snp_pkg::ST_EMIT : snp_pkg::ST_WD_RD;
      snp_pkg::ST_EMIT: if (!pend_q || out_free) state_d = after_q;
      snp_pkg::ST_FLUSH: if (!pend_q || out_free) state_d = snp_pkg::ST_IDLE;
      default: state_d = snp_pkg::ST_IDLE;
    endcase
  end

  // datapath
  snp_pkg::result_t er;
  logic emit_go;

  assign rx.ready  = state_q == snp_pkg::ST_IDLE;
  assign res.valid = ovalid_q;
  assign res.data  = out_q;

  always_comb begin
    head_d = head_q; fill_d = fill_q; pos_d = pos_q; sub_d = sub_q;
    b0_d = b0_q; b1_d = b1_q; typ_d = typ_q; addr_d = addr_q; dlen_d = dlen_q;
    sum_d = sum_q; word_d = word_q; widx_d = widx_q; nres_d = nres_q;
    rxb_d = rxb_q; new_d = new_q; after_d = after_q;
    out_d = out_q; ovalid_d = ovalid_q && !res.ready;
    pres_d = pres_q; pend_d = pend_q;
    er = '0; emit_go = 1'b0;
    case (state_q)
      snp_pkg::ST_IDLE: begin
        rxb_d = rx.data;
        pos_d = fill_q - CW'(2);
        sub_d = '0;
      end
      snp_pkg::ST_TRIM_CHK: begin
        if (sub_q == 2'd0) begin
          b1_d = rdata; pos_d = pos_q + CW'(1); sub_d = 2'd1;
        end else begin
          head_d = wrap(head_q, fill_q - keep_c); fill_d = keep_c;
        end
      end
      snp_pkg::ST_WRITE: begin
        fill_d = fill_q + CW'(1); nres_d = '0;
      end
      snp_pkg::ST_START: begin
        pos_d = '0; sub_d = '0; sum_d = snp_pkg::HdrSum;
      end
      snp_pkg::ST_SCAN_CHK: begin
        // window of the last three bytes read
        b0_d = b1_q; b1_d = rdata;
        pos_d = pos_q + CW'(1);
        if (hdr_hit) begin
          if (pos_q != CW'(2)) begin
            // header further in: drop what lies before it
            head_d = wrap(head_q, pos_q - CW'(2)); fill_d = fill_q - (pos_q - CW'(2));
            er.event_res = snp_pkg::EV_GARBAGE; emit_go = 1'b1;
          end
        end else if (scan_end) begin
          head_d = wrap(head_q, fill_q - keep_c); fill_d = keep_c;
          er.event_res = snp_pkg::EV_GARBAGE; emit_go = 1'b1;
        end
      end
      snp_pkg::ST_HDR_CHK: begin
        sum_d = add_y;
        pos_d = pos_q + CW'(1);
        if (pos_q == CW'(3)) begin
          typ_d = rdata;
        end else begin
          addr_d = rdata; dlen_d = dlen_c;
          if (bad_type) begin
            head_d = wrap(head_q, CW'(1)); fill_d = fill_q - CW'(1);
            er.event_res = snp_pkg::EV_BAD_TYPE; emit_go = 1'b1;
          end
        end
      end
      snp_pkg::ST_SUM_ACC: begin
        sum_d = add_y; pos_d = pos_q + CW'(1);
      end
      snp_pkg::ST_CK_CMP: begin
        // checksum arrives high byte first
        pos_d = pos_q + CW'(1);
        if (sub_q == 2'd0) begin
          b0_d = rdata; sub_d = 2'd1;
        end else begin
          sub_d = 2'd0;
          if (!sum_ok) begin
            head_d = wrap(head_q, CW'(1)); fill_d = fill_q - CW'(1);
            er.event_res = snp_pkg::EV_CSUM; emit_go = 1'b1;
          end else if (no_room) begin
            // packet waits for the next byte
          end else if (dlen_q == '0) begin
            er.event_res = snp_pkg::EV_READY; er.reg_address = addr_q;
            er.type_byte = typ_q;
            head_d = wrap(head_q, CW'(7)); fill_d = fill_q - CW'(7);
            emit_go = 1'b1;
          end else begin
            pos_d = CW'(5); widx_d = '0;
          end
        end
      end
      snp_pkg::ST_WD_ACC: begin
        word_d = {word_q[23:0], rdata};
        pos_d = pos_q + CW'(1); sub_d = sub_q + 2'd1;
        if (sub_q == 2'd3) begin
          er.event_res = snp_pkg::EV_READY; er.reg_address = addr_q;
          er.type_byte = typ_q; er.payload_bytes = dlen_q[5:0];
          er.data_word = {word_q[23:0], rdata}; er.word_index = widx_q;
          widx_d = widx_q + 4'd1;
          if (last_word) begin
            head_d = wrap(head_q, CW'(7) + CW'(dlen_q));
            fill_d = fill_q - (CW'(7) + CW'(dlen_q));
          end
          emit_go = 1'b1;
        end
      end
      snp_pkg::ST_EMIT: begin
        // park the new result; the one parked before goes out without last
        if (!pend_q) begin
          pres_d = new_q; pend_d = 1'b1;
        end else if (out_free) begin
          out_d = pres_q; out_d.last = 1'b0; ovalid_d = 1'b1;
          pres_d = new_q;
        end
      end
      snp_pkg::ST_FLUSH: begin
        // end of step: the parked result is the final one
        if (pend_q && out_free) begin
          out_d = pres_q; out_d.last = 1'b1; ovalid_d = 1'b1; pend_d = 1'b0;
        end
      end
      default: ;
    endcase
    if (emit_go) begin
      new_d = er;
      nres_d = nres_q + 7'd1;
      after_d = (state_q == snp_pkg::ST_WD_ACC && !last_word) ? snp_pkg::ST_WD_RD
                                                              : snp_pkg::ST_START;
    end
  end

  `SNP_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni,
    state_q != snp_pkg::ST_IDLE, !rx.ready)
  `SNP_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= CW'(BUFFER_BYTES))
  `SNP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, ovalid_q && !res.ready,
    ovalid_q && $stable(out_q))
endmodule
`default_nettype wire
